>>> hw/rtl/bmpc_pkg.sv
package bmpc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_LONG_PRESS   = 3'd1,
    REG_SHORT_MAX    = 3'd2,
    REG_SERIES_WIN   = 3'd3,
    REG_COMPANION    = 3'd4
  } cfg_reg_t;

  // message codes
  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_SINGLE = 2'd1,
    MSG_DOUBLE = 2'd2
  } msg_kind_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 2;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd40;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] SHORT_MAX_RST  = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] SERIES_WIN_RST = 16'd600;

  // press count saturates here; a series of this many presses pings
  localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

endpackage

>>> hw/rtl/bmpc_if.sv
// sample channel
interface bmpc_sample_if import bmpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              button_pressed;
  logic [TIME_W-1:0] time_ms;
  logic              update_busy;

  modport source (output valid, button_pressed, time_ms, update_busy, input ready);
  modport sink   (input valid, button_pressed, time_ms, update_busy, output ready);
endinterface

// result channel
interface bmpc_result_if import bmpc_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      toggle_display;
  logic      wake_display;
  logic      send_ping;
  logic [1:0] message_kind;

  modport source (output valid, toggle_display, wake_display, send_ping, message_kind,
                  input ready);
  modport sink   (input valid, toggle_display, wake_display, send_ping, message_kind,
                  output ready);
endinterface

>>> hw/rtl/button_multi_press_classifier.sv
// channel   dir   word
// sample    in    button_pressed, time_ms[31:0], update_busy
// result    out   toggle_display, wake_display, send_ping, message_kind[1:0]
// cfg       in    cfg_we, cfg_index[2:0], cfg_data[15:0] (write only)
//
// one sample per cycle while ready; its result is registered in the result register
// the path is one 32-bit subtract and compare per time check on the press state
// rst (synchronous) restores register defaults and clears press state and result valid
// a stalled result holds the sample side only while the result register is full
module button_multi_press_classifier import bmpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  bmpc_sample_if.sink           sample,
  bmpc_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [CFG_DATA_W-1:0] debounce_ms;
  logic [CFG_DATA_W-1:0] long_press_ms;
  logic [CFG_DATA_W-1:0] short_press_max_ms;
  logic [CFG_DATA_W-1:0] series_window_ms;
  logic                  companion_mode;

  // press state
  logic                  level_held;
  logic [TIME_W-1:0]     last_edge_time;
  logic [TIME_W-1:0]     press_start_time;
  logic [COUNT_W-1:0]    press_count;

  logic                  level_held_next;
  logic [TIME_W-1:0]     last_edge_time_next;
  logic [TIME_W-1:0]     press_start_time_next;
  logic [COUNT_W-1:0]    press_count_next;

  logic                  accept;
  logic [TIME_W-1:0]     since_edge;
  logic [TIME_W-1:0]     held;
  logic                  edge_ok;
  logic                  series_end;
  logic [COUNT_W-1:0]    count_after;
  logic                  toggle_next;
  logic                  wake_next;
  logic                  ping_next;
  msg_kind_t             kind_next;

  // result register frees the sample side whenever it is empty or draining
  assign sample.ready = !result.valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms        <= DEBOUNCE_RST;
      long_press_ms      <= LONG_PRESS_RST;
      short_press_max_ms <= SHORT_MAX_RST;
      series_window_ms   <= SERIES_WIN_RST;
      companion_mode     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ms        <= cfg_data;
        REG_LONG_PRESS: long_press_ms      <= cfg_data;
        REG_SHORT_MAX:  short_press_max_ms <= cfg_data;
        REG_SERIES_WIN: series_window_ms   <= cfg_data;
        REG_COMPANION:  companion_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // edge qualification and hold timing, all differences wrap
  assign since_edge = sample.time_ms - last_edge_time;
  assign held       = sample.time_ms - press_start_time;
  assign edge_ok    = !sample.update_busy && (sample.button_pressed != level_held) &&
                      (since_edge > TIME_W'(debounce_ms));

  // press classification and series end
  always_comb begin
    level_held_next       = level_held;
    last_edge_time_next   = last_edge_time;
    press_start_time_next = press_start_time;
    count_after           = press_count;
    toggle_next           = 1'b0;
    wake_next             = 1'b0;
    ping_next             = 1'b0;
    kind_next             = MSG_NONE;
    series_end            = 1'b0;

    if (edge_ok) begin
      level_held_next     = sample.button_pressed;
      last_edge_time_next = sample.time_ms;
      if (sample.button_pressed) begin
        press_start_time_next = sample.time_ms;
      end else begin
        priority if (held >= TIME_W'(long_press_ms)) begin
          toggle_next = 1'b1;
        end else if (held < TIME_W'(short_press_max_ms)) begin
          if (press_count != COUNT_MAX) begin
            count_after = press_count + COUNT_W'(1);
          end
        end else begin
          // middle hold leaves the series alone
          count_after = press_count;
        end
      end
    end

    // a fresh edge restarts the window, so only a quiet sample can end a series
    series_end = !sample.update_busy && !edge_ok && (press_count != '0) && !level_held &&
                 (since_edge > TIME_W'(series_window_ms));

    press_count_next = count_after;
    if (series_end) begin
      press_count_next = '0;
      wake_next        = 1'b1;
      if (press_count == COUNT_MAX) begin
        ping_next = 1'b1;
      end else if (!companion_mode) begin
        kind_next = (press_count == COUNT_TWO) ? MSG_DOUBLE : MSG_SINGLE;
      end
    end
  end

  // state update on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      level_held       <= 1'b0;
      last_edge_time   <= '0;
      press_start_time <= '0;
      press_count      <= '0;
    end else if (accept) begin
      level_held       <= level_held_next;
      last_edge_time   <= last_edge_time_next;
      press_start_time <= press_start_time_next;
      press_count      <= press_count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (sample.ready) begin
      result.valid <= sample.valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result.toggle_display <= toggle_next;
      result.wake_display   <= wake_next;
      result.send_ping      <= ping_next;
      result.message_kind   <= kind_next;
    end
  end

  // a ping always comes with a wake
  a_ping_wakes: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.send_ping |-> result.wake_display)
    else $error("ping without wake");

  // a message excludes a ping and needs a wake
  a_msg_wakes: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.message_kind != MSG_NONE) |->
      result.wake_display && !result.send_ping)
    else $error("message without wake or with ping");

  // a toggle needs an edge, a series end needs a quiet sample
  a_toggle_excl_wake: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.wake_display |-> !result.toggle_display)
    else $error("toggle and wake in one result");

  // a frozen sample leaves the press state alone and yields an empty result
  a_busy_frozen: assert property (@(posedge clk) disable iff (rst)
    accept && sample.update_busy |=>
      $stable(press_count) && $stable(last_edge_time) && $stable(level_held) &&
      !result.toggle_display && !result.wake_display)
    else $error("state moved on a frozen sample");

endmodule
